@@ design/trd_pkg.sv @@
`default_nettype none

package trd_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int TS_W   = 16;
  localparam int WORD_W = 24;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // Depth of the pulse queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SHORT_MIN = 2'd0;
  localparam logic [IDX_W-1:0] REG_SHORT_MAX = 2'd1;
  localparam logic [IDX_W-1:0] REG_LONG_MIN  = 2'd2;
  localparam logic [IDX_W-1:0] REG_LONG_MAX  = 2'd3;

  // Reset values: nominal 350 and 1050 ticks with a quarter tolerance.
  localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd262;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd437;
  localparam logic [CFG_W-1:0] LONG_MIN_RST  = 16'd787;
  localparam logic [CFG_W-1:0] LONG_MAX_RST  = 16'd1312;

  // Pulse kinds: width class plus the level that just ended.
  typedef logic [2:0] pulse_t;
  localparam pulse_t PULSE_S0  = 3'd0;
  localparam pulse_t PULSE_S1  = 3'd1;
  localparam pulse_t PULSE_L0  = 3'd2;
  localparam pulse_t PULSE_L1  = 3'd3;
  localparam pulse_t PULSE_BAD = 3'd4;

  // Frame decoder states.
  typedef logic [3:0] frame_t;
  localparam frame_t ST_IDLE = 4'd0;
  localparam frame_t ST_S    = 4'd1;
  localparam frame_t ST_SL   = 4'd2;
  localparam frame_t ST_SLS  = 4'd3;
  localparam frame_t ST_B0   = 4'd4;
  localparam frame_t ST_SLL  = 4'd5;
  localparam frame_t ST_BF   = 4'd6;
  localparam frame_t ST_L    = 4'd7;
  localparam frame_t ST_LS   = 4'd8;
  localparam frame_t ST_LSL  = 4'd9;
  localparam frame_t ST_B1   = 4'd10;

  // Symbol codes in the packed code word.
  typedef logic [1:0] sym_t;
  localparam sym_t SYM_ZERO  = 2'd0;
  localparam sym_t SYM_ONE   = 2'd1;
  localparam sym_t SYM_FLOAT = 2'd2;

  // Pulse detection thresholds.
  typedef struct packed {
    logic [CFG_W-1:0] short_min;
    logic [CFG_W-1:0] short_max;
    logic [CFG_W-1:0] long_min;
    logic [CFG_W-1:0] long_max;
  } thresh_t;

  // Queue write side and read side.
  typedef struct packed {
    logic   push;
    pulse_t kind;
  } q_wr_t;

  typedef struct packed {
    logic   avail;
    pulse_t kind;
  } q_rd_t;

  // Frame table: next state for a state and a pulse kind.
  // Codes outside the table behave as the initial state.
  function automatic frame_t frame_next(frame_t st, pulse_t kind);
    frame_t nxt;
    nxt = ST_IDLE;
    case (st)
      ST_S:   if (kind == PULSE_L0) nxt = ST_SL;
      ST_SL: begin
        if (kind == PULSE_S1) nxt = ST_SLS;
        else if (kind == PULSE_L1) nxt = ST_SLL;
      end
      ST_SLS: if (kind == PULSE_L0) nxt = ST_B0;
      ST_SLL: if (kind == PULSE_S0) nxt = ST_BF;
      ST_L:   if (kind == PULSE_S0) nxt = ST_LS;
      ST_LS:  if (kind == PULSE_L1) nxt = ST_LSL;
      ST_LSL: if (kind == PULSE_S0) nxt = ST_B1;
      default: begin
        // Idle and the three symbol states start a new symbol.
        if (kind == PULSE_S1) nxt = ST_S;
        else if (kind == PULSE_L1) nxt = ST_L;
      end
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

@@ design/trd_sample_if.sv @@
`default_nettype none

interface trd_sample_if import trd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] timestamp;
  logic            pin_level;

  modport source (output valid, output timestamp, output pin_level, input ready);
  modport sink (input valid, input timestamp, input pin_level, output ready);
endinterface

`default_nettype wire

@@ design/trd_code_if.sv @@
`default_nettype none

interface trd_code_if import trd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] code_word;

  modport source (output valid, output code_word, input ready);
  modport sink (input valid, input code_word, output ready);
endinterface

`default_nettype wire

@@ design/trd_front.sv @@
`default_nettype none

module trd_front import trd_pkg::*; #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  trd_sample_if.sink            sample,
  input  wire logic             q_full,
  output q_wr_t                 q_wr
);

  localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  thresh_t                thr;
  logic                   last_level;
  logic [TIMER_WIDTH-1:0] edge_time;
  logic [TIMER_WIDTH-1:0] now;
  logic [TIMER_WIDTH-1:0] width;
  logic [CMP_W-1:0]       wx;
  logic                   take;
  logic                   edge_seen;
  logic                   short_hit;
  logic                   long_hit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.short_min <= SHORT_MIN_RST;
      thr.short_max <= SHORT_MAX_RST;
      thr.long_min  <= LONG_MIN_RST;
      thr.long_max  <= LONG_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SHORT_MIN: thr.short_min <= cfg_data;
        REG_SHORT_MAX: thr.short_max <= cfg_data;
        REG_LONG_MIN:  thr.long_min  <= cfg_data;
        REG_LONG_MAX:  thr.long_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A word is taken whenever the queue has room.
  assign sample.ready = !q_full;
  assign take         = sample.valid && !q_full;
  assign edge_seen    = take && (sample.pin_level != last_level);

  // Wrapped pulse width since the previous edge.
  assign now   = TIMER_WIDTH'(sample.timestamp);
  assign width = now - edge_time;
  assign wx    = CMP_W'(width);

  // Window tests; the short window wins where both match.
  assign short_hit = (CMP_W'(thr.short_min) < wx) && (wx < CMP_W'(thr.short_max));
  assign long_hit  = (CMP_W'(thr.long_min) < wx) && (wx < CMP_W'(thr.long_max));

  always_comb begin
    q_wr.push = edge_seen;
    if (short_hit) q_wr.kind = last_level ? PULSE_S1 : PULSE_S0;
    else if (long_hit) q_wr.kind = last_level ? PULSE_L1 : PULSE_L0;
    else q_wr.kind = PULSE_BAD;
  end

  // Edge tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b0;
      edge_time  <= '0;
    end else if (edge_seen) begin
      last_level <= sample.pin_level;
      edge_time  <= now;
    end
  end

endmodule

`default_nettype wire

@@ design/trd_queue.sv @@
`default_nettype none

module trd_queue import trd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire q_wr_t q_wr,
  output logic       q_full,
  input  wire logic  pop,
  output q_rd_t      q_rd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  pulse_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] occ;
  logic             do_push;
  logic             do_pop;

  assign q_full     = (occ == OCC_W'(QUEUE_DEPTH));
  assign q_rd.avail = (occ != '0);
  assign q_rd.kind  = entries[rd_ptr];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = pop && q_rd.avail;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= q_wr.kind;
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) occ <= occ + 1'b1;
      else if (do_pop && !do_push) occ <= occ - 1'b1;
    end
  end

  // Occupancy never exceeds the depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("pulse queue occupancy above depth");

  // A push and no pop grows the occupancy by one.
  a_occ_grow: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (occ == $past(occ) + 1'b1))
    else $error("pulse queue lost a push");

endmodule

`default_nettype wire

@@ design/trd_back.sv @@
`default_nettype none

module trd_back import trd_pkg::*; #(
  parameter int SYMBOLS = 12
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire q_rd_t q_rd,
  output logic       pop,
  trd_code_if.source code
);

  localparam int CNT_W = $clog2(SYMBOLS + 1);

  frame_t            frame_state;
  frame_t            state_next;
  logic [CNT_W-1:0]  symbol_count;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] shifted;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              is_sym;
  sym_t              sym;
  logic              last_sym;
  logic              emit;

  // Take a pulse whenever the output register is free or being drained.
  assign pop        = q_rd.avail && (!out_valid || code.ready);
  assign state_next = frame_next(frame_state, q_rd.kind);

  // Symbol decode of the new state.
  always_comb begin
    is_sym = 1'b1;
    case (state_next)
      ST_B0:   sym = SYM_ZERO;
      ST_B1:   sym = SYM_ONE;
      ST_BF:   sym = SYM_FLOAT;
      default: begin
        sym    = SYM_ZERO;
        is_sym = 1'b0;
      end
    endcase
  end

  // The first symbol of a frame starts a clean word.
  assign shifted  = (symbol_count == '0) ? {(WORD_W - 2)'(0), sym}
                                         : {acc[WORD_W-3:0], sym};
  assign last_sym = (symbol_count == CNT_W'(SYMBOLS - 1));
  assign emit     = pop && is_sym && last_sym;

  // Frame state and symbol count.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state  <= ST_IDLE;
      symbol_count <= '0;
    end else if (pop) begin
      frame_state <= state_next;
      if (state_next == ST_IDLE || (is_sym && last_sym)) begin
        symbol_count <= '0;
      end else if (is_sym) begin
        symbol_count <= symbol_count + 1'b1;
      end
    end
  end

  // Symbol accumulator.
  always_ff @(posedge clk) begin
    if (pop && is_sym) acc <= shifted;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (code.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_word <= shifted;
  end

  assign code.valid     = out_valid;
  assign code.code_word = out_word;

  // The symbol count stays below a full frame.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    symbol_count < CNT_W'(SYMBOLS))
    else $error("symbol count reached a full frame");

  // Only table states are ever reached.
  a_state_bound: assert property (@(posedge clk) disable iff (rst)
    frame_state <= ST_B1)
    else $error("frame state outside the table");

  // A finished frame shows a word and restarts the count.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && symbol_count == '0))
    else $error("finished frame not delivered");

  // No pulse is taken while a waiting word is stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !code.ready) |-> !pop)
    else $error("pulse taken over a stalled word");

endmodule

`default_nettype wire

@@ design/tristate_rf_remote_decoder.sv @@
`default_nettype none

// Channel   Dir  Fields                       Handshake
// sample    in   timestamp[15:0], pin_level   valid/ready
// code      out  code_word[23:0]              valid/ready
// cfg       in   cfg_index[1:0], cfg_data     cfg_wr_en, no wait
//
// One sample word is taken every cycle while the queue has room; the front
// measures and classifies an edge in the cycle it is taken and writes the
// pulse to a 2-entry queue. The back runs one frame table step per cycle
// unless its output stalls, and code words are shown from a register.
// Synchronous reset clears edge tracking, the frame state, the queue and the
// output register, and reloads the pulse thresholds.
// A stalled code word holds the back; sample ready falls when the queue fills.

module tristate_rf_remote_decoder import trd_pkg::*; #(
  parameter int SYMBOLS     = 12,
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  trd_sample_if.sink            sample,
  trd_code_if.source            code,
  input  wire logic             cfg_wr_en,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  // Edge detection and pulse classification.
  trd_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  // Pulse queue.
  trd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  // Frame decoding and word assembly.
  trd_back #(
    .SYMBOLS(SYMBOLS)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .q_rd (q_rd),
    .pop  (pop),
    .code (code)
  );

endmodule

`default_nettype wire

@@ tb/tb_tristate_rf_remote_decoder.sv @@
`default_nettype none

module tb_tristate_rf_remote_decoder;
  import trd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_SYMS  = 12;
  localparam int ITEM_TARGET = 1350;
  localparam int WORD_TARGET = 36;
  localparam int SETTLE_CYC  = 8;
  localparam int HOLD_CYC    = 400;

  // Width classes of a measured pulse, before the ended level is attached.
  localparam int CLS_SHORT = 0;
  localparam int CLS_LONG  = 1;
  localparam int CLS_BAD   = 2;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  trd_sample_if sample_ch ();
  trd_code_if   code_ch ();

  tristate_rf_remote_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .code      (code_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Decoder mirror: thresholds, edge tracking, frame state and symbols.
  thresh_t           win;
  logic              line_level;
  logic [TS_W-1:0]   last_edge;
  frame_t            frame_st;
  int                sym_count;
  sym_t              sym_buf [FRAME_SYMS];
  logic [WORD_W-1:0] pending_words [$];

  int  errors;
  int  n_samples;
  int  n_edges;
  int  n_predicted;
  int  n_words_seen;
  bit  tx_calm;
  bit  rx_calm;
  bit  rx_hold;
  int  rx_left;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int width_class(input logic [TS_W-1:0] w);
    if (win.short_min < w && w < win.short_max) return CLS_SHORT;
    if (win.long_min < w && w < win.long_max) return CLS_LONG;
    return CLS_BAD;
  endfunction

  // Frame table, organized by pulse kind. The three symbol states behave
  // like idle: they can only start the next symbol.
  function automatic frame_t frame_after(input frame_t st, input pulse_t k);
    logic at_rest;
    at_rest = (st == ST_IDLE) || (st == ST_B0) || (st == ST_B1) || (st == ST_BF);
    case (k)
      PULSE_S0: begin
        if (st == ST_SLL) return ST_BF;
        if (st == ST_L) return ST_LS;
        if (st == ST_LSL) return ST_B1;
      end
      PULSE_S1: begin
        if (at_rest) return ST_S;
        if (st == ST_SL) return ST_SLS;
      end
      PULSE_L0: begin
        if (st == ST_S) return ST_SL;
        if (st == ST_SLS) return ST_B0;
      end
      PULSE_L1: begin
        if (at_rest) return ST_L;
        if (st == ST_SL) return ST_SLL;
        if (st == ST_LS) return ST_LSL;
      end
      default: ;
    endcase
    return ST_IDLE;
  endfunction

  // Advance the mirror by one accepted sample and queue any finished word.
  function automatic void decode_sample(input logic [TS_W-1:0] ts, input logic lvl);
    logic [TS_W-1:0]   w;
    int                cls;
    pulse_t            k;
    sym_t              s;
    logic [WORD_W-1:0] word;
    if (lvl == line_level) return;
    n_edges++;
    w = ts - last_edge;
    cls = width_class(w);
    if (cls == CLS_SHORT) k = line_level ? PULSE_S1 : PULSE_S0;
    else if (cls == CLS_LONG) k = line_level ? PULSE_L1 : PULSE_L0;
    else k = PULSE_BAD;
    line_level = lvl;
    last_edge = ts;
    frame_st = frame_after(frame_st, k);
    case (frame_st)
      ST_B0: s = SYM_ZERO;
      ST_B1: s = SYM_ONE;
      ST_BF: s = SYM_FLOAT;
      ST_IDLE: begin
        sym_count = 0;
        return;
      end
      default: return;
    endcase
    if (sym_count >= FRAME_SYMS) sym_count = 0;
    sym_buf[sym_count] = s;
    sym_count++;
    if (sym_count < FRAME_SYMS) return;
    // First symbol lands in the top pair.
    word = '0;
    for (int i = 0; i < FRAME_SYMS; i++) word = {word[WORD_W-3:0], sym_buf[i]};
    sym_count = 0;
    pending_words.push_back(word);
    n_predicted++;
  endfunction

  function automatic int tx_nap();
    return tx_calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic int rx_nap();
    return rx_calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic take_word(input logic [WORD_W-1:0] got);
    logic [WORD_W-1:0] want;
    n_words_seen++;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("code word %06h with none predicted", got));
      return;
    end
    want = pending_words.pop_front();
    if (got !== want) report_mismatch($sformatf("code word %06h, predicted %06h", got, want));
  endtask

  // Code side: after each word a wait is drawn, and it only runs down while
  // a word is actually waiting, so the stall lands on the back of the block.
  always @(posedge clk) begin : code_side
    int left;
    if (rst) begin
      code_ch.ready <= 1'b0;
      rx_left <= 0;
    end else begin
      left = rx_left;
      if (code_ch.valid && code_ch.ready) begin
        take_word(code_ch.code_word);
        left = rx_nap();
      end else if (code_ch.valid && left > 0) begin
        left = left - 1;
      end
      rx_left <= left;
      code_ch.ready <= (left == 0) && !rx_hold;
    end
  end

  // One long hold-off on the code side while samples keep coming, so the
  // pulse queue fills and the sample side stalls.
  initial begin : long_hold
    rx_hold = 1'b0;
    wait (n_edges >= 250);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Offer one sample word after a drawn gap and wait until it is taken.
  // Called in the time step of a rising edge.
  task automatic put_sample(input logic [TS_W-1:0] ts, input logic lvl);
    int gap;
    gap = tx_nap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.timestamp <= ts;
    sample_ch.pin_level <= lvl;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    n_samples++;
    decode_sample(ts, lvl);
  endtask

  // Hold the current level for the given width, then flip it. Now and then
  // a sample at the current level goes first; the block must ignore it.
  task automatic pulse(input logic [TS_W-1:0] w);
    logic [TS_W-1:0] idle_ts;
    if ($urandom_range(0, 9) == 0) begin
      idle_ts = $urandom_range(0, 65535);
      put_sample(idle_ts, line_level);
    end
    put_sample(last_edge + w, ~line_level);
  endtask

  function automatic logic [TS_W-1:0] window_width(input bit long_p);
    int lo;
    int hi;
    lo = long_p ? win.long_min : win.short_min;
    hi = long_p ? win.long_max : win.short_max;
    if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic [TS_W-1:0] bad_width();
    logic [TS_W-1:0] w;
    w = '0;
    for (int i = 0; i < 16; i++) begin
      w = $urandom_range(0, 65535);
      if (width_class(w) == CLS_BAD) return w;
    end
    return w;
  endfunction

  // Which of the four pulses of a symbol are long, first pulse in bit 0.
  function automatic logic [3:0] long_marks(input sym_t s);
    case (s)
      SYM_ZERO: return 4'b1010;
      SYM_ONE:  return 4'b0101;
      default:  return 4'b0110;
    endcase
  endfunction

  // A sync gap of invalid pulses, leaving the pin high and the frame idle,
  // then the symbols. One pulse can be replaced by a random width.
  task automatic send_frame(input int nsym, input int spoil_at);
    int          n;
    sym_t        s;
    logic [3:0]  marks;
    if (line_level) pulse(bad_width());
    pulse(bad_width());
    n = 0;
    for (int i = 0; i < nsym; i++) begin
      case ($urandom_range(0, 2))
        0:       s = SYM_ZERO;
        1:       s = SYM_ONE;
        default: s = SYM_FLOAT;
      endcase
      marks = long_marks(s);
      for (int j = 0; j < 4; j++) begin
        if (n == spoil_at) pulse($urandom_range(0, 65535));
        else pulse(window_width(marks[j]));
        n++;
      end
    end
  endtask

  task automatic one_round();
    int pick;
    int cnt;
    logic [TS_W-1:0] ts;
    logic lvl;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_frame(FRAME_SYMS, -1);
    end else if (pick < 80) begin
      send_frame($urandom_range(FRAME_SYMS + 1, 2 * FRAME_SYMS), -1);
    end else if (pick < 90) begin
      send_frame(FRAME_SYMS, $urandom_range(0, 4 * FRAME_SYMS - 1));
    end else begin
      // Line noise: arbitrary samples.
      cnt = $urandom_range(1, 8);
      for (int i = 0; i < cnt; i++) begin
        ts = $urandom_range(0, 65535);
        lvl = $urandom_range(0, 1);
        put_sample(ts, lvl);
      end
    end
  endtask

  task automatic random_burst(input int budget);
    int start;
    start = n_edges;
    while (n_edges - start < budget) one_round();
  endtask

  // Stop offering samples and let every predicted word drain out.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic poke(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SHORT_MIN: win.short_min = val;
      REG_SHORT_MAX: win.short_max = val;
      REG_LONG_MIN:  win.long_min = val;
      default:       win.long_max = val;
    endcase
  endtask

  task automatic load_windows(input thresh_t t);
    poke(REG_SHORT_MIN, t.short_min);
    poke(REG_SHORT_MAX, t.short_max);
    poke(REG_LONG_MIN, t.long_min);
    poke(REG_LONG_MAX, t.long_max);
    cfg_wr_en <= 1'b0;
  endtask

  // Directed walk under the reset thresholds. A row gives either an
  // absolute timestamp or a step from the previous one, and the pin level.
  typedef struct packed {
    logic            absolute;
    logic [TS_W-1:0] value;
    logic            lvl;
  } walk_row_t;

  walk_row_t walk [23] = '{
    // No edge, then a width equal to the short lower bound (invalid).
    '{1'b1, 16'd100, 1'b0},
    '{1'b1, 16'd262, 1'b1},
    // Window edges from inside: the four pulses of a '0' symbol.
    '{1'b0, 16'd263, 1'b0},
    '{1'b0, 16'd788, 1'b1},
    '{1'b0, 16'd436, 1'b0},
    '{1'b0, 16'd1311, 1'b1},
    // Short upper bound, a repeated sample, long bounds, a stray long low.
    '{1'b0, 16'd437, 1'b0},
    '{1'b0, 16'd0, 1'b0},
    '{1'b0, 16'd787, 1'b1},
    '{1'b0, 16'd1312, 1'b0},
    '{1'b0, 16'd1050, 1'b1},
    // Top of the timer, then a pulse that wraps through zero.
    '{1'b1, 16'd65535, 1'b0},
    '{1'b0, 16'd350, 1'b1},
    // A '1' symbol, then an 'F' symbol.
    '{1'b0, 16'd1050, 1'b0},
    '{1'b0, 16'd350, 1'b1},
    '{1'b0, 16'd1050, 1'b0},
    '{1'b0, 16'd350, 1'b1},
    '{1'b0, 16'd350, 1'b0},
    '{1'b0, 16'd1050, 1'b1},
    '{1'b0, 16'd1050, 1'b0},
    '{1'b0, 16'd350, 1'b1},
    // Timestamp zero without an edge, then an edge of zero width.
    '{1'b1, 16'd0, 1'b1},
    '{1'b1, 16'd5949, 1'b0}
  };

  initial begin : stimulus
    logic [TS_W-1:0] ts;
    thresh_t t;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.timestamp = '0;
    sample_ch.pin_level = 1'b0;
    code_ch.ready = 1'b0;
    errors = 0;
    n_samples = 0;
    n_edges = 0;
    n_predicted = 0;
    n_words_seen = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    win = '{SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST};
    line_level = 1'b0;
    last_edge = '0;
    frame_st = ST_IDLE;
    sym_count = 0;
    ts = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk, then frames under the reset thresholds.
    foreach (walk[i]) begin
      ts = walk[i].absolute ? walk[i].value : ts + walk[i].value;
      put_sample(ts, walk[i].lvl);
    end
    random_burst(300);

    // Random disjoint windows, with no idling on either side.
    settle();
    t.short_min = $urandom_range(20, 400);
    t.short_max = t.short_min + $urandom_range(3, 300);
    t.long_min  = t.short_max + $urandom_range(0, 500);
    t.long_max  = t.long_min + $urandom_range(3, 2000);
    load_windows(t);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    random_burst(300);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Overlapping windows: the short window wins.
    settle();
    load_windows('{16'd300, 16'd1200, 16'd200, 16'd2000});
    random_burst(100);

    // Extremes: short window takes nearly all, long window empty.
    settle();
    load_windows('{16'd0, 16'd65535, 16'd65535, 16'd0});
    random_burst(60);

    // Extremes the other way round.
    settle();
    load_windows('{16'd65535, 16'd0, 16'd0, 16'd65535});
    random_burst(60);

    // Narrowest usable windows, one width each.
    settle();
    load_windows('{16'd10, 16'd12, 16'd20, 16'd22});
    random_burst(200);

    // Back to the nominal thresholds for the rest.
    settle();
    load_windows('{SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST});
    while (n_samples < ITEM_TARGET || n_predicted < WORD_TARGET) one_round();

    settle();
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d predicted code words never came", pending_words.size()));
    $display("Sent %0d samples (%0d edges) over seven threshold settings.", n_samples, n_edges);
    $display("Checked %0d code words against %0d predicted.", n_words_seen, n_predicted);
    if (errors == 0) begin
      $display("tb_tristate_rf_remote_decoder: done, clean");
    end else begin
      $display("tb_tristate_rf_remote_decoder: done, errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #5000000;
    $display("Timed out with %0d code words outstanding.", pending_words.size());
    $display("tb_tristate_rf_remote_decoder: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
